>>> hdl/assert_macros.svh
// concurrent assertion macros used by the execution unit core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define WSEU_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define WSEU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/wseu_pkg.sv
// package: opcodes, status codes, sequencer states and sizes of the stack execution unit
`default_nettype none

package wseu_pkg;

    localparam int STACK_DEPTH_DEF = 1024;
    localparam int LIMIT_W         = 11;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 11'd1024;

    typedef enum logic [4:0] {
        OP_NOP         = 5'd0,
        OP_UNREACHABLE = 5'd1,
        OP_RETURN      = 5'd2,
        OP_SELECT      = 5'd3,
        OP_DROP        = 5'd4,
        OP_DROP_KEEP   = 5'd5,
        OP_ALLOCA      = 5'd6,
        OP_I32_CONST   = 5'd7,
        OP_I64_CONST   = 5'd8,
        OP_F32_CONST   = 5'd9,
        OP_F64_CONST   = 5'd10,
        OP_GET_LOCAL   = 5'd11,
        OP_SET_LOCAL   = 5'd12,
        OP_TEE_LOCAL   = 5'd13,
        OP_I32_ADD     = 5'd14,
        OP_I32_SUB     = 5'd15,
        OP_I32_MUL     = 5'd16,
        OP_I32_DIV_S   = 5'd17,
        OP_I32_REM_S   = 5'd18,
        OP_I32_AND     = 5'd19,
        OP_I32_OR      = 5'd20,
        OP_I32_XOR     = 5'd21,
        OP_I32_SHL     = 5'd22,
        OP_I32_SHR_S   = 5'd23,
        OP_I32_SHR_U   = 5'd24,
        OP_I32_ROTL    = 5'd25,
        OP_I32_ROTR    = 5'd26,
        OP_I64_ADD     = 5'd27,
        OP_I64_SUB     = 5'd28,
        OP_I64_MUL     = 5'd29,
        OP_I64_DIV_S   = 5'd30,
        OP_I64_REM_S   = 5'd31
    } t_op;

    typedef enum logic [2:0] {
        STAT_OK          = 3'd0,
        STAT_RETURNED    = 3'd1,
        STAT_UNREACHABLE = 3'd2,
        STAT_EXHAUSTED   = 3'd3,
        STAT_DIV_ZERO    = 3'd4,
        STAT_OVERFLOW    = 3'd5
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DEC,
        S_RDB,
        S_RDC,
        S_EXEC,
        S_MUL,
        S_DIV,
        S_DIVFIN,
        S_ACOMMIT,
        S_FILL,
        S_TOPRD,
        S_TOPCAP
    } t_state;

endpackage

`default_nettype wire

>>> hdl/wasm_stack_execution_unit_core.sv
// wasm integer stack execution unit: sequencer around one value stack memory
// nop, traps and pushes finish in the execute state; operand reads pass through the read states
//   and a pop rereads the new top; mul sums 32-bit partial products, div/rem produces one quotient
//   bit per cycle; alloca zeroes the new entries one by one; one transaction at a time, busy high
//   until done; the stack memory has one write port and one read port with registered read data
// synchronous active-low reset clears height and sets the limit to its reset value; stack contents are not cleared
`default_nettype none

module wasm_stack_execution_unit_core
    import wseu_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire logic [4:0]          i_operation,
    input  wire logic signed [63:0]  i_immediate,
    input  wire logic                i_keep_one,
    input  wire logic                i_cfg_wr_en,
    input  wire logic [LIMIT_W-1:0]  i_cfg_wr_data,
    output logic                     o_valid,
    output logic [2:0]               o_status,
    output logic signed [63:0]       o_top_value,
    output logic [10:0]              o_stack_height
);

    `include "assert_macros.svh"

    localparam int HW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = (HW > LIMIT_W) ? HW : LIMIT_W;
    localparam logic [63:0] MIN64 = 64'h8000_0000_0000_0000;

    function automatic logic [63:0] mag(input logic [63:0] v);
        return v[63] ? (64'd0 - v) : v;
    endfunction

    // control
    t_state             r_state, n_state;
    logic [HW-1:0]      r_height, n_height;
    logic [LIMIT_W-1:0] r_limit;
    logic               r_o_valid, n_o_valid;

    // payload
    t_op           r_op, n_op;
    logic [63:0]   r_imm, n_imm;
    logic          r_keep, n_keep;
    logic [63:0]   r_top, n_top;
    logic [63:0]   r_a, n_a;
    logic [63:0]   r_b, n_b;
    logic [63:0]   r_res, n_res;
    logic [63:0]   r_prod, n_prod;
    logic [6:0]    r_cnt, n_cnt;
    logic [HW-1:0] r_fill, n_fill;
    logic          r_neg_q, n_neg_q, r_neg_r, n_neg_r, r_is_rem, n_is_rem, r_is32, n_is32;
    t_status       r_o_status, n_o_status;
    logic [63:0]   r_o_top, n_o_top;
    logic [10:0]   r_o_height, n_o_height;

    // stack memory
    logic [63:0]   r_mem [STACK_DEPTH];
    logic [63:0]   r_rdata;
    logic          mem_we, mem_re;
    logic [AW-1:0] mem_wa, mem_ra;
    logic [63:0]   mem_wd;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rdata <= r_mem[mem_ra];
        end
    end

    always_comb begin
        logic [HW-1:0] lim, hh, pop_h, d, hm1;
        logic          need_a, need_b, loc_ok, set_ok;
        logic [AW-1:0] addr_a, addr_b;
        logic          fin;
        t_status       fin_st;
        logic [HW-1:0] fin_h;
        logic [63:0]   fin_top;
        logic          do_push, do_pop;
        logic [63:0]   push_v, opb, sa, sb, v, xx, dbl_l, dbl_r, rem_sh, prod;
        logic [31:0]   x, y, v32, mul_x, mul_y;
        logic [4:0]    sh;
        logic          is64, ovf;

        n_state = r_state; n_height = r_height; n_o_valid = 1'b0;
        n_op = r_op; n_imm = r_imm; n_keep = r_keep; n_top = r_top;
        n_a = r_a; n_b = r_b; n_res = r_res; n_prod = r_prod; n_cnt = r_cnt; n_fill = r_fill;
        n_neg_q = r_neg_q; n_neg_r = r_neg_r; n_is_rem = r_is_rem; n_is32 = r_is32;
        n_o_status = r_o_status; n_o_top = r_o_top; n_o_height = r_o_height;
        mem_we = 1'b0; mem_wa = '0; mem_wd = '0; mem_re = 1'b0; mem_ra = '0;
        fin = 1'b0; fin_st = STAT_OK; fin_h = r_height; fin_top = r_top;
        do_push = 1'b0; push_v = '0; do_pop = 1'b0; pop_h = '0; d = '0;

        lim = (CW'(r_limit) > CW'(STACK_DEPTH)) ? HW'(STACK_DEPTH) : HW'(r_limit);
        hh  = (r_height >= HW'(2)) ? (r_height - HW'(2)) : '0;
        hm1 = r_height - HW'(1);
        loc_ok = (r_imm != 64'd0) && (r_imm <= 64'(r_height));
        set_ok = (r_imm != 64'd0) && (r_imm <= 64'(hm1));

        opb = (r_height != '0) ? r_top : '0;
        x = r_a[31:0];
        y = opb[31:0];
        sh = y[4:0];
        xx = {x, x};
        dbl_l = xx << sh;
        dbl_r = xx >> sh;
        is64 = (r_op >= OP_I64_ADD);
        sa = is64 ? r_a : {{32{x[31]}}, x};
        sb = is64 ? opb : {{32{y[31]}}, y};
        ovf = is64 ? ((r_a == MIN64) && (opb == '1)) : ((x == 32'h8000_0000) && (y == '1));
        v32 = '0;
        v = '0;
        rem_sh = {r_prod[62:0], r_a[63]};

        unique case (r_cnt[1:0])
            2'd0: begin mul_x = r_a[31:0];  mul_y = r_b[31:0];  end
            2'd1: begin mul_x = r_a[31:0];  mul_y = r_b[63:32]; end
            2'd2: begin mul_x = r_a[63:32]; mul_y = r_b[31:0];  end
            default: begin mul_x = '0; mul_y = '0; end
        endcase
        prod = 64'(mul_x) * 64'(mul_y);

        need_a = 1'b0; need_b = 1'b0;
        addr_a = AW'(r_height - HW'(2));
        addr_b = AW'(r_height - HW'(3));
        if (r_op == OP_SELECT) begin
            need_a = (r_height >= HW'(2));
            need_b = (r_height >= HW'(3));
        end else if (r_op >= OP_I32_ADD) begin
            need_a = (r_height >= HW'(2));
        end else if (r_op == OP_GET_LOCAL) begin
            need_a = loc_ok;
            addr_a = AW'(r_height - HW'(r_imm));
        end

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_op = t_op'(i_operation);
                    n_imm = i_immediate;
                    n_keep = i_keep_one;
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                n_a = '0;
                n_b = '0;
                if (need_a) begin
                    mem_re = 1'b1;
                    mem_ra = addr_a;
                    n_state = S_RDB;
                end else begin
                    n_state = S_EXEC;
                end
            end
            S_RDB: begin
                n_a = r_rdata;
                if (need_b) begin
                    mem_re = 1'b1;
                    mem_ra = addr_b;
                    n_state = S_RDC;
                end else begin
                    n_state = S_EXEC;
                end
            end
            S_RDC: begin
                n_b = r_rdata;
                n_state = S_EXEC;
            end
            S_EXEC: begin
                unique case (r_op)
                    OP_NOP: fin = 1'b1;
                    OP_UNREACHABLE: begin fin = 1'b1; fin_st = STAT_UNREACHABLE; end
                    OP_RETURN: begin fin = 1'b1; fin_st = STAT_RETURNED; end
                    OP_SELECT: begin
                        fin = 1'b1;
                        if (r_height < HW'(2)) begin
                            fin_h = '0;
                        end else if (r_top[31:0] == 32'd0) begin
                            fin_h = (r_height >= HW'(3)) ? hh : HW'(1);
                            fin_top = r_a;
                            mem_we = 1'b1;
                            mem_wa = AW'(fin_h - HW'(1));
                            mem_wd = r_a;
                        end else begin
                            fin_h = hh;
                            fin_top = r_b;
                        end
                    end
                    OP_DROP: begin
                        do_pop = 1'b1;
                        pop_h = (r_height != '0) ? hm1 : '0;
                    end
                    OP_DROP_KEEP: begin
                        if (r_keep && (r_height != '0)) begin
                            d = (r_imm > 64'(hm1)) ? hm1 : HW'(r_imm);
                            fin = 1'b1;
                            fin_h = r_height - d;
                            mem_we = 1'b1;
                            mem_wa = AW'(fin_h - HW'(1));
                            mem_wd = r_top;
                        end else begin
                            d = (r_imm > 64'(r_height)) ? r_height : HW'(r_imm);
                            do_pop = 1'b1;
                            pop_h = r_height - d;
                        end
                    end
                    OP_ALLOCA: begin
                        if ((r_height >= lim) || (r_imm >= 64'(lim - r_height))) begin
                            fin = 1'b1;
                            fin_st = STAT_EXHAUSTED;
                        end else if (r_imm == 64'd0) begin
                            fin = 1'b1;
                        end else begin
                            n_fill = HW'(r_imm);
                            n_state = S_FILL;
                        end
                    end
                    OP_I32_CONST, OP_F32_CONST: begin
                        do_push = 1'b1;
                        push_v = {32'd0, r_imm[31:0]};
                    end
                    OP_I64_CONST, OP_F64_CONST: begin
                        do_push = 1'b1;
                        push_v = r_imm;
                    end
                    OP_GET_LOCAL: begin
                        do_push = 1'b1;
                        push_v = r_a;
                    end
                    OP_SET_LOCAL: begin
                        if (r_height == '0) begin
                            fin = 1'b1;
                        end else begin
                            if (set_ok) begin
                                mem_we = 1'b1;
                                mem_wa = AW'(hm1 - HW'(r_imm));
                                mem_wd = r_top;
                            end
                            do_pop = 1'b1;
                            pop_h = hm1;
                        end
                    end
                    OP_TEE_LOCAL: begin
                        fin = 1'b1;
                        if (loc_ok) begin
                            mem_we = 1'b1;
                            mem_wa = AW'(r_height - HW'(r_imm));
                            mem_wd = r_top;
                        end
                    end
                    OP_I32_ADD, OP_I32_SUB, OP_I32_AND, OP_I32_OR, OP_I32_XOR,
                    OP_I32_SHL, OP_I32_SHR_S, OP_I32_SHR_U, OP_I32_ROTL, OP_I32_ROTR: begin
                        priority case (r_op)
                            OP_I32_ADD:   v32 = x + y;
                            OP_I32_SUB:   v32 = x - y;
                            OP_I32_AND:   v32 = x & y;
                            OP_I32_OR:    v32 = x | y;
                            OP_I32_XOR:   v32 = x ^ y;
                            OP_I32_SHL:   v32 = x << sh;
                            OP_I32_SHR_S: v32 = 32'($signed(x) >>> sh);
                            OP_I32_SHR_U: v32 = x >> sh;
                            OP_I32_ROTL:  v32 = dbl_l[63:32];
                            default:      v32 = dbl_r[31:0];
                        endcase
                        n_res = {32'd0, v32};
                        n_state = S_ACOMMIT;
                    end
                    OP_I64_ADD: begin n_res = r_a + opb; n_state = S_ACOMMIT; end
                    OP_I64_SUB: begin n_res = r_a - opb; n_state = S_ACOMMIT; end
                    OP_I32_MUL, OP_I64_MUL: begin
                        n_a = is64 ? r_a : {32'd0, x};
                        n_b = is64 ? opb : {32'd0, y};
                        n_is32 = !is64;
                        n_cnt = '0;
                        n_state = S_MUL;
                    end
                    OP_I32_DIV_S, OP_I32_REM_S, OP_I64_DIV_S, OP_I64_REM_S: begin
                        n_is_rem = (r_op == OP_I32_REM_S) || (r_op == OP_I64_REM_S);
                        n_is32 = !is64;
                        if (sb == 64'd0) begin
                            fin = 1'b1;
                            fin_st = STAT_DIV_ZERO;
                        end else if (ovf && !n_is_rem) begin
                            fin = 1'b1;
                            fin_st = STAT_OVERFLOW;
                        end else if (ovf) begin
                            n_res = '0;
                            n_state = S_ACOMMIT;
                        end else begin
                            n_a = mag(sa);
                            n_b = mag(sb);
                            n_prod = '0;
                            n_neg_q = sa[63] ^ sb[63];
                            n_neg_r = sa[63];
                            n_cnt = 7'd64;
                            n_state = S_DIV;
                        end
                    end
                endcase

                if (do_push) begin
                    fin = 1'b1;
                    if (r_height >= lim) begin
                        fin_st = STAT_EXHAUSTED;
                    end else begin
                        mem_we = 1'b1;
                        mem_wa = AW'(r_height);
                        mem_wd = push_v;
                        fin_h = r_height + HW'(1);
                        fin_top = push_v;
                    end
                end
                if (do_pop) begin
                    if (pop_h == '0) begin
                        fin = 1'b1;
                        fin_h = '0;
                    end else begin
                        n_height = pop_h;
                        n_state = S_TOPRD;
                    end
                end
            end
            S_MUL: begin
                n_cnt = r_cnt + 7'd1;
                n_prod = prod;
                unique case (r_cnt[1:0])
                    2'd0: n_res = '0;
                    2'd1: n_res = r_prod;
                    2'd2: n_res = r_res + {r_prod[31:0], 32'd0};
                    default: begin
                        v = r_res + {r_prod[31:0], 32'd0};
                        n_res = r_is32 ? {32'd0, v[31:0]} : v;
                        n_state = S_ACOMMIT;
                    end
                endcase
            end
            S_DIV: begin
                if (rem_sh >= r_b) begin
                    n_prod = rem_sh - r_b;
                    n_a = {r_a[62:0], 1'b1};
                end else begin
                    n_prod = rem_sh;
                    n_a = {r_a[62:0], 1'b0};
                end
                n_cnt = r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    n_state = S_DIVFIN;
                end
            end
            S_DIVFIN: begin
                if (r_is_rem) begin
                    v = r_neg_r ? (64'd0 - r_prod) : r_prod;
                end else begin
                    v = r_neg_q ? (64'd0 - r_a) : r_a;
                end
                n_res = r_is32 ? {32'd0, v[31:0]} : v;
                n_state = S_ACOMMIT;
            end
            S_ACOMMIT: begin
                fin = 1'b1;
                if (hh >= lim) begin
                    fin_st = STAT_EXHAUSTED;
                end else begin
                    mem_we = 1'b1;
                    mem_wa = AW'(hh);
                    mem_wd = r_res;
                    fin_h = hh + HW'(1);
                    fin_top = r_res;
                end
            end
            S_FILL: begin
                mem_we = 1'b1;
                mem_wa = AW'(r_height);
                mem_wd = '0;
                n_height = r_height + HW'(1);
                n_fill = r_fill - HW'(1);
                if (r_fill == HW'(1)) begin
                    fin = 1'b1;
                    fin_h = r_height + HW'(1);
                    fin_top = '0;
                end
            end
            S_TOPRD: begin
                mem_re = 1'b1;
                mem_ra = AW'(hm1);
                n_state = S_TOPCAP;
            end
            S_TOPCAP: begin
                fin = 1'b1;
                fin_top = r_rdata;
            end
        endcase

        if (fin) begin
            n_o_valid = 1'b1;
            n_o_status = fin_st;
            n_o_height = 11'(fin_h);
            n_o_top = (fin_h != '0) ? fin_top : '0;
            n_height = fin_h;
            n_top = fin_top;
            n_state = S_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_height <= '0;
            r_limit <= LIMIT_RESET;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_height <= n_height;
            r_o_valid <= n_o_valid;
            if (i_cfg_wr_en) begin
                r_limit <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op <= n_op;
        r_imm <= n_imm;
        r_keep <= n_keep;
        r_top <= n_top;
        r_a <= n_a;
        r_b <= n_b;
        r_res <= n_res;
        r_prod <= n_prod;
        r_cnt <= n_cnt;
        r_fill <= n_fill;
        r_neg_q <= n_neg_q;
        r_neg_r <= n_neg_r;
        r_is_rem <= n_is_rem;
        r_is32 <= n_is32;
        r_o_status <= n_o_status;
        r_o_top <= n_o_top;
        r_o_height <= n_o_height;
    end

    assign busy = (r_state != S_IDLE);
    assign o_valid = r_o_valid;
    assign o_status = r_o_status;
    assign o_top_value = r_o_top;
    assign o_stack_height = r_o_height;

    `WSEU_ASSERT_NEXT(a_start_busy, start && !busy, busy, "accepted transaction did not raise busy")
    `WSEU_ASSERT_NOW(a_valid_from_busy, o_valid, $past(r_state) != S_IDLE, "result without work")
    `WSEU_ASSERT_NOW(a_height_match, o_valid, o_stack_height == 11'(r_height), "height mismatch")
    `WSEU_ASSERT_NOW(a_no_rw_overlap, mem_we && mem_re, mem_wa != mem_ra, "read during write")

endmodule

`default_nettype wire

>>> tb/wasm_stack_execution_unit_core_tb.sv
// testbench: directed table and random instruction streams checked vs fixed rows or a stack predictor
`default_nettype none

module wasm_stack_execution_unit_core_tb;
    import wseu_pkg::*;

    typedef struct packed {
        t_status     st;
        logic [63:0] top;
        logic [10:0] height;
    } outcome_t;

    typedef struct {
        t_op         op;
        logic [63:0] imm;
        logic        keep;
        bit          typed;
        t_status     st;
        logic [63:0] top;
        int          height;
    } row_t;

    localparam logic [63:0] MIN64 = 64'h8000_0000_0000_0000;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic [4:0]        i_operation = '0;
    logic signed [63:0] i_immediate = '0;
    logic              i_keep_one = 1'b0;
    logic              i_cfg_wr_en = 1'b0;
    logic [LIMIT_W-1:0] i_cfg_wr_data = '0;
    logic              o_valid;
    logic [2:0]        o_status;
    logic signed [63:0] o_top_value;
    logic [10:0]       o_stack_height;

    // typed expectation travelling with the current transaction
    bit       fixed_exp = 0;
    outcome_t fixed_val;

    logic [63:0] stk [0:STACK_DEPTH_DEF-1];
    int unsigned stk_height = 0;
    int unsigned stk_limit = 1024;
    outcome_t    pending[$];
    int          accepted = 0;
    int          errors = 0;
    row_t        rows[];

    wasm_stack_execution_unit_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_operation(i_operation), .i_immediate(i_immediate), .i_keep_one(i_keep_one),
        .i_cfg_wr_en(i_cfg_wr_en), .i_cfg_wr_data(i_cfg_wr_data),
        .o_valid(o_valid), .o_status(o_status), .o_top_value(o_top_value),
        .o_stack_height(o_stack_height)
    );

    always #5 i_clk = ~i_clk;

    function automatic int unsigned eff_limit();
        return (stk_limit > STACK_DEPTH_DEF) ? STACK_DEPTH_DEF : stk_limit;
    endfunction

    function automatic void shrink(int unsigned h0, logic [63:0] cnt, bit keep);
        int unsigned nh;
        if (keep && h0 > 0) begin
            nh = h0 - ((cnt > h0 - 1) ? h0 - 1 : cnt[31:0]);
            stk[nh-1] = stk[h0-1];
        end else begin
            nh = h0 - ((cnt > h0) ? h0 : cnt[31:0]);
        end
        stk_height = nh;
    endfunction

    function automatic t_status push(logic [63:0] v);
        if (stk_height >= eff_limit()) return STAT_EXHAUSTED;
        stk[stk_height] = v;
        stk_height++;
        return STAT_OK;
    endfunction

    function automatic t_status alu(t_op op, logic [63:0] a, logic [63:0] b,
                                    output logic [63:0] r);
        logic [31:0] x, y, v;
        logic [4:0]  s;
        x = a[31:0];
        y = b[31:0];
        s = y[4:0];
        r = '0;
        v = '0;
        case (op)
            OP_I64_ADD: r = a + b;
            OP_I64_SUB: r = a - b;
            OP_I64_MUL: r = a * b;
            OP_I64_DIV_S, OP_I64_REM_S: begin
                if (b == 0) return STAT_DIV_ZERO;
                if (a == MIN64 && b == '1) begin
                    if (op == OP_I64_DIV_S) return STAT_OVERFLOW;
                    r = '0;
                end else if (op == OP_I64_DIV_S) begin
                    r = $signed(a) / $signed(b);
                end else begin
                    r = $signed(a) % $signed(b);
                end
            end
            default: begin
                case (op)
                    OP_I32_ADD: v = x + y;
                    OP_I32_SUB: v = x - y;
                    OP_I32_MUL: v = x * y;
                    OP_I32_DIV_S, OP_I32_REM_S: begin
                        if (y == 0) return STAT_DIV_ZERO;
                        if (x == 32'h8000_0000 && y == '1) begin
                            if (op == OP_I32_DIV_S) return STAT_OVERFLOW;
                            v = '0;
                        end else if (op == OP_I32_DIV_S) begin
                            v = $signed(x) / $signed(y);
                        end else begin
                            v = $signed(x) % $signed(y);
                        end
                    end
                    OP_I32_AND:   v = x & y;
                    OP_I32_OR:    v = x | y;
                    OP_I32_XOR:   v = x ^ y;
                    OP_I32_SHL:   v = x << s;
                    OP_I32_SHR_S: v = $signed(x) >>> s;
                    OP_I32_SHR_U: v = x >> s;
                    OP_I32_ROTL:  v = (s == 0) ? x : ((x << s) | (x >> (6'd32 - s)));
                    default:      v = (s == 0) ? x : ((x >> s) | (x << (6'd32 - s)));
                endcase
                r = {32'h0, v};
            end
        endcase
        return STAT_OK;
    endfunction

    function automatic outcome_t execute(t_op op, logic [63:0] imm, logic keep);
        outcome_t    o;
        t_status     st;
        int unsigned h, hh, lim;
        logic [63:0] a, b, r;
        h = stk_height;
        st = STAT_OK;
        case (op)
            OP_NOP: ;
            OP_UNREACHABLE: st = STAT_UNREACHABLE;
            OP_RETURN: st = STAT_RETURNED;
            OP_SELECT: begin
                if (h == 0) shrink(0, 1, 0);
                else shrink(h - 1, 1, stk[h-1][31:0] == 0);
            end
            OP_DROP: shrink(h, 1, 0);
            OP_DROP_KEEP: shrink(h, imm, keep);
            OP_ALLOCA: begin
                lim = eff_limit();
                if (h >= lim || imm >= 64'(lim - h)) begin
                    st = STAT_EXHAUSTED;
                end else begin
                    for (int i = 0; i < imm; i++) stk[h+i] = '0;
                    stk_height = h + imm[31:0];
                end
            end
            OP_I32_CONST, OP_F32_CONST: st = push({32'h0, imm[31:0]});
            OP_I64_CONST, OP_F64_CONST: st = push(imm);
            OP_GET_LOCAL: st = push((imm >= 1 && imm <= h) ? stk[h - imm[31:0]] : '0);
            OP_SET_LOCAL: begin
                if (h > 0) begin
                    hh = h - 1;
                    if (imm >= 1 && imm <= hh) stk[hh - imm[31:0]] = stk[hh];
                    stk_height = hh;
                end
            end
            OP_TEE_LOCAL: begin
                if (imm >= 1 && imm <= h) stk[h - imm[31:0]] = stk[h-1];
            end
            default: begin
                a = '0;
                b = '0;
                hh = h;
                if (hh > 0) begin hh--; b = stk[hh]; end
                if (hh > 0) begin hh--; a = stk[hh]; end
                st = alu(op, a, b, r);
                if (st == STAT_OK) begin
                    if (hh >= eff_limit()) begin
                        st = STAT_EXHAUSTED;
                    end else begin
                        stk[hh] = r;
                        stk_height = hh + 1;
                    end
                end
            end
        endcase
        o.st = st;
        o.top = stk_height ? stk[stk_height-1] : '0;
        o.height = stk_height[10:0];
        return o;
    endfunction

    // transaction acceptance and result checking
    always @(posedge i_clk) begin
        outcome_t e, p;
        if (i_rst_n && start && !busy) begin
            p = execute(t_op'(i_operation), i_immediate, i_keep_one);
            pending.push_back(fixed_exp ? fixed_val : p);
            accepted++;
        end
        if (i_rst_n && o_valid) begin
            if (pending.size() == 0) begin
                $display("%0t: unexpected result status %0d top %h height %0d",
                         $time, o_status, o_top_value, o_stack_height);
                errors++;
            end else begin
                e = pending.pop_front();
                if (o_status !== e.st) begin
                    $display("%0t: status expected %0d actual %0d", $time, e.st, o_status);
                    errors++;
                end
                if (o_top_value !== e.top) begin
                    $display("%0t: top expected %h actual %h", $time, e.top, o_top_value);
                    errors++;
                end
                if (o_stack_height !== e.height) begin
                    $display("%0t: height expected %0d actual %0d", $time, e.height,
                             o_stack_height);
                    errors++;
                end
            end
        end
    end

    task automatic send(t_op op, logic [63:0] imm, logic keep, bit idle_ok);
        int target;
        if (idle_ok && $urandom_range(0, 99) < 17) begin
            start = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        i_operation = op;
        i_immediate = imm;
        i_keep_one = keep;
        start = 1'b1;
        target = accepted + 1;
        do @(negedge i_clk); while (accepted != target);
    endtask

    task automatic drain();
        start = 1'b0;
        while (pending.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic set_limit(int unsigned v);
        i_cfg_wr_data = v[LIMIT_W-1:0];
        i_cfg_wr_en = 1'b1;
        @(negedge i_clk);
        i_cfg_wr_en = 1'b0;
        stk_limit = v;
    endtask

    function automatic logic [63:0] pick_value();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return 64'd1;
            2: return '1;
            3: return MIN64;
            4: return ~MIN64;
            5: return 64'h0000_0000_8000_0000;
            6: return 64'h0000_0000_FFFF_FFFF;
            7: return 64'(  $urandom_range(0, 40));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic random_item(bit idle_ok);
        int unsigned r, h;
        t_op         op;
        logic [63:0] imm;
        h = stk_height;
        r = $urandom_range(0, 99);
        imm = {$urandom, $urandom};
        if (r < 30 || h < 2 && r < 50) begin
            op = t_op'($urandom_range(OP_I32_CONST, OP_F64_CONST));
            imm = pick_value();
        end else if (r < 50) begin
            op = t_op'($urandom_range(OP_GET_LOCAL, OP_TEE_LOCAL));
            if ($urandom_range(0, 9) != 0) imm = 64'($urandom_range(0, h + 1));
        end else if (r < 55) begin
            op = OP_SELECT;
        end else if (r < 60) begin
            op = OP_DROP;
        end else if (r < 64) begin
            op = OP_DROP_KEEP;
            if ($urandom_range(0, 7) != 0) imm = 64'($urandom_range(0, 4));
        end else if (r < 67) begin
            op = OP_ALLOCA;
            if ($urandom_range(0, 7) != 0) imm = 64'($urandom_range(0, 6));
        end else if (r < 70) begin
            op = t_op'($urandom_range(OP_NOP, OP_RETURN));
        end else begin
            op = t_op'($urandom_range(OP_I32_ADD, OP_I64_REM_S));
        end
        send(op, imm, 1'($urandom_range(0, 1)), idle_ok);
    endtask

    initial begin
        int unsigned limits[5] = '{1024, 5, 2047, 1, 700};
        rows = '{
            '{OP_NOP,         64'd0, 0, 1, STAT_OK,          64'd0, 0},
            '{OP_DROP,        64'd0, 0, 1, STAT_OK,          64'd0, 0},
            '{OP_UNREACHABLE, 64'd0, 0, 1, STAT_UNREACHABLE, 64'd0, 0},
            '{OP_RETURN,      64'd0, 0, 1, STAT_RETURNED,    64'd0, 0},
            '{OP_I64_ADD,     64'd0, 0, 1, STAT_OK,          64'd0, 1},
            '{OP_I64_CONST,   MIN64, 0, 1, STAT_OK,          MIN64, 2},
            '{OP_I64_CONST,   '1,    1, 1, STAT_OK,          '1,    3},
            '{OP_I64_DIV_S,   64'd0, 0, 1, STAT_OVERFLOW,    '1,    3},
            '{OP_I64_REM_S,   64'd0, 0, 1, STAT_OK,          64'd0, 2},
            '{OP_I32_CONST,   64'd0, 0, 1, STAT_OK,          64'd0, 3},
            '{OP_I32_DIV_S,   64'd0, 0, 1, STAT_DIV_ZERO,    64'd0, 3},
            '{OP_I32_CONST,   64'hFFFF_FFFF_8000_0000, 0, 1, STAT_OK,
              64'h8000_0000, 4},
            '{OP_I32_CONST,   '1,    0, 1, STAT_OK,          64'hFFFF_FFFF, 5},
            '{OP_I32_DIV_S,   64'd0, 0, 1, STAT_OVERFLOW,    64'hFFFF_FFFF, 5},
            '{OP_I32_REM_S,   64'd0, 0, 1, STAT_OK,          64'd0, 4},
            '{OP_F64_CONST,   64'h7FF0_0000_0000_0001, 0, 0, STAT_OK, 0, 0},
            '{OP_F32_CONST,   '1,    0, 0, STAT_OK, 0, 0},
            '{OP_I32_ROTL,    64'd0, 0, 0, STAT_OK, 0, 0},
            '{OP_GET_LOCAL,   64'd0, 0, 0, STAT_OK, 0, 0},
            '{OP_GET_LOCAL,   64'd3, 0, 0, STAT_OK, 0, 0},
            '{OP_TEE_LOCAL,   64'd2, 0, 0, STAT_OK, 0, 0},
            '{OP_SET_LOCAL,   64'd9, 0, 0, STAT_OK, 0, 0},
            '{OP_SELECT,      64'd0, 0, 0, STAT_OK, 0, 0},
            '{OP_DROP_KEEP,   64'd2, 1, 0, STAT_OK, 0, 0},
            '{OP_ALLOCA,      64'd3, 0, 0, STAT_OK, 0, 0}
        };
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);
        foreach (rows[i]) begin
            fixed_exp = rows[i].typed;
            fixed_val = '{rows[i].st, rows[i].top, rows[i].height[10:0]};
            send(rows[i].op, rows[i].imm, rows[i].keep, 0);
        end
        fixed_exp = 0;
        for (int p = 0; p < 5; p++) begin
            drain();
            set_limit(limits[p]);
            for (int n = 0; n < 90; n++) random_item(p != 2 || n > 80);
        end
        drain();
        if (errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

`default_nettype wire
